// ===== sv/x86ex_pkg.sv =====
package x86ex_pkg;

	// Default stack store depth in words (a power of two).
	localparam int STACK_WORDS_DEF = 1024;

	// Depth of the decoded-instruction queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Architectural reset values.
	localparam logic [15:0] IP_RESET = 16'h2000;
	localparam logic [15:0] SP_RESET = 16'hFFFE;

	// Configuration register indexes.
	localparam logic REG_CODE_SEG  = 1'b0;
	localparam logic REG_STACK_SEG = 1'b1;

	// Run status codes.
	localparam logic [1:0] RUN_OK   = 2'd0;
	localparam logic [1:0] RUN_HALT = 2'd1;
	localparam logic [1:0] RUN_BAD  = 2'd2;

	// Opcode bytes of the supported subset.
	localparam logic [7:0] OPC_MOV_AX = 8'hB8;
	localparam logic [7:0] OPC_MOV_CX = 8'hB9;
	localparam logic [7:0] OPC_MOV_DX = 8'hBA;
	localparam logic [7:0] OPC_MOV_BX = 8'hBB;
	localparam logic [7:0] OPC_MOV_SP = 8'hBC;
	localparam logic [7:0] OPC_MOV_BP = 8'hBD;
	localparam logic [7:0] OPC_MOV_SI = 8'hBE;
	localparam logic [7:0] OPC_MOV_DI = 8'hBF;
	localparam logic [7:0] OPC_MOV_AH = 8'hB4;
	localparam logic [7:0] OPC_MOV_AL = 8'hB0;
	localparam logic [7:0] OPC_INT    = 8'hCD;
	localparam logic [7:0] OPC_PUSH   = 8'h50;
	localparam logic [7:0] OPC_POP    = 8'h58;
	localparam logic [7:0] OPC_CALL   = 8'hE8;
	localparam logic [7:0] OPC_RET    = 8'hC3;
	localparam logic [7:0] OPC_HLT    = 8'hF4;
	localparam logic [7:0] OPC_CMP    = 8'h3D;
	localparam logic [7:0] OPC_DEC_CX = 8'h49;
	localparam logic [7:0] OPC_JE     = 8'h74;
	localparam logic [7:0] OPC_JNE    = 8'h75;
	localparam logic [7:0] OPC_JL     = 8'h7C;
	localparam logic [7:0] OPC_JG     = 8'h7F;
	localparam logic [7:0] OPC_JMP    = 8'hEB;

	// Video interrupt number and its teletype function code.
	localparam logic [7:0] INT_VIDEO    = 8'h10;
	localparam logic [7:0] AH_TELETYPE  = 8'h0E;

	// Operation classes produced by the front decoder.
	typedef enum logic [3:0] {
		K_NOP,
		K_MOV_AX,
		K_MOV_CX,
		K_MOV_SP,
		K_MOV_AH,
		K_MOV_AL,
		K_CHAR,
		K_PUSH,
		K_POP,
		K_CALL,
		K_RET,
		K_HLT,
		K_CMP,
		K_DEC,
		K_JCC,
		K_BAD
	} kind_t;

	// Branch conditions.
	typedef enum logic [2:0] {
		C_JE,
		C_JNE,
		C_JL,
		C_JG,
		C_JMP
	} cond_t;

	// One decoded instruction as it sits in the queue.
	typedef struct packed {
		kind_t       kind;
		cond_t       cond;
		logic [1:0]  len;
		logic [15:0] imm;
	} dec_t;

	// One result item, laid out so that next_ip lands in the lowest bits.
	typedef struct packed {
		logic [4:0]  pad;
		logic [1:0]  run_status;
		logic [7:0]  char_byte;
		logic        char_valid;
		logic        ovf_flag;
		logic        sgn_flag;
		logic        zro_flag;
		logic        carry_flag;
		logic [15:0] stack_pointer;
		logic [15:0] count_register;
		logic [15:0] accumulator;
		logic [19:0] fetch_address;
		logic [15:0] next_ip;
	} res_t;

endpackage

// ===== sv/x86ex_ram.sv =====
module x86ex_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/x86ex_front.sv =====
module x86ex_front
	import x86ex_pkg::*;
(
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        q_full,
	input  logic        clearing,
	output logic        q_push,
	output dec_t        q_data
);

	logic [7:0]  opcode;
	logic [15:0] immediate;
	logic [7:0]  lo;

	assign opcode    = s_tdata[7:0];
	assign immediate = s_tdata[23:8];
	assign lo        = immediate[7:0];

	// Items are taken whenever the queue has room and the stack store is ready.
	assign s_tready = !q_full && !clearing;
	assign q_push   = s_tvalid && s_tready;

	// Classify the opcode and work out its length and operand.
	always_comb begin
		q_data.kind = K_BAD;
		q_data.cond = C_JMP;
		q_data.len  = 2'd1;
		q_data.imm  = immediate;
		unique case (opcode) inside
			OPC_MOV_AX: begin
				q_data.kind = K_MOV_AX;
				q_data.len  = 2'd3;
			end
			OPC_MOV_CX: begin
				q_data.kind = K_MOV_CX;
				q_data.len  = 2'd3;
			end
			OPC_MOV_SP: begin
				q_data.kind = K_MOV_SP;
				q_data.len  = 2'd3;
			end
			// Registers that never reach a result only move the IP.
			OPC_MOV_DX, OPC_MOV_BX, OPC_MOV_BP, OPC_MOV_SI, OPC_MOV_DI: begin
				q_data.kind = K_NOP;
				q_data.len  = 2'd3;
			end
			OPC_MOV_AH: begin
				q_data.kind = K_MOV_AH;
				q_data.len  = 2'd2;
			end
			OPC_MOV_AL: begin
				q_data.kind = K_MOV_AL;
				q_data.len  = 2'd2;
			end
			OPC_INT: begin
				q_data.kind = (lo == INT_VIDEO) ? K_CHAR : K_NOP;
				q_data.len  = 2'd2;
			end
			OPC_PUSH: begin
				q_data.kind = K_PUSH;
				q_data.len  = 2'd1;
			end
			OPC_POP: begin
				q_data.kind = K_POP;
				q_data.len  = 2'd1;
			end
			OPC_CALL: begin
				q_data.kind = K_CALL;
				q_data.len  = 2'd3;
			end
			OPC_RET: begin
				q_data.kind = K_RET;
				q_data.len  = 2'd0;
			end
			OPC_HLT: begin
				q_data.kind = K_HLT;
				q_data.len  = 2'd1;
			end
			OPC_CMP: begin
				q_data.kind = K_CMP;
				q_data.len  = 2'd3;
			end
			OPC_DEC_CX: begin
				q_data.kind = K_DEC;
				q_data.len  = 2'd1;
			end
			OPC_JE, OPC_JNE, OPC_JL, OPC_JG, OPC_JMP: begin
				q_data.kind = K_JCC;
				q_data.len  = 2'd2;
				q_data.imm  = {{8{lo[7]}}, lo};
				case (opcode)
					OPC_JE:  q_data.cond = C_JE;
					OPC_JNE: q_data.cond = C_JNE;
					OPC_JL:  q_data.cond = C_JL;
					OPC_JG:  q_data.cond = C_JG;
					default: q_data.cond = C_JMP;
				endcase
			end
			default: begin
				q_data.kind = K_BAD;
				q_data.len  = 2'd1;
			end
		endcase
	end

endmodule

// ===== sv/x86ex_queue.sv =====
module x86ex_queue
	import x86ex_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dec_t push_data,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output dec_t head_data
);

	dec_t        entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full       = (count_q == (PW + 1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/x86ex_back.sv =====
module x86ex_back
	import x86ex_pkg::*;
#(
	parameter int STACK_WORDS = STACK_WORDS_DEF,
	localparam int AW = $clog2(STACK_WORDS)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] code_seg,
	input  logic [15:0] stack_seg,
	input  logic        head_valid,
	input  dec_t        head_data,
	output logic        pop,
	output logic        clearing,
	output logic        m_tvalid,
	input  logic        m_tready,
	output res_t        m_data
);

	// Architectural state.
	logic [15:0] ip_q, sp_q, ax_q, cx_q;
	logic        cf_q, zf_q, sf_q, of_q;
	logic [1:0]  run_q;

	// Stack read in flight, clearing sweep and result register.
	logic        pend_q;
	logic [AW:0] clr_q;
	logic        out_valid_q;
	res_t        out_q;

	// Next-state values.
	logic [15:0] ip_n, sp_n, ax_n, cx_n;
	logic        cf_n, zf_n, sf_n, of_n;
	logic [1:0]  run_n;
	logic        cv_n;
	logic [7:0]  cb_n;
	logic        push_n;
	logic [15:0] push_val;
	logic [15:0] ip_seq;
	logic [16:0] cmp_diff;
	logic [15:0] dec_val;
	logic        take;

	logic        out_free, need_read, go, issue, fin;
	logic        ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0] ram_rdata;

	// Stack word index: 20-bit segment address, word granular, wrapped to the store.
	function automatic logic [AW-1:0] word_idx(input logic [15:0] seg, input logic [15:0] ptr);
		logic [19:0] a;
		a = {seg, 4'b0000} + {4'b0000, ptr};
		return a[AW:1];
	endfunction

	assign clearing = !clr_q[AW];
	assign out_free = !out_valid_q || m_tready;
	assign need_read = (run_q == RUN_OK) &&
		(head_data.kind == K_POP || head_data.kind == K_RET);
	assign go    = head_valid && out_free && !clearing;
	assign issue = go && need_read && !pend_q;
	assign fin   = go && (!need_read || pend_q);
	assign pop   = fin;

	assign ip_seq   = ip_q + {14'b0, head_data.len};
	assign cmp_diff = {1'b0, ax_q} - {1'b0, head_data.imm};
	assign dec_val  = cx_q - 16'd1;

	// Branch condition from the current flags.
	always_comb begin
		case (head_data.cond)
			C_JE:    take = zf_q;
			C_JNE:   take = !zf_q;
			C_JL:    take = (sf_q != of_q);
			C_JG:    take = !zf_q && (sf_q == of_q);
			default: take = 1'b1;
		endcase
	end

	// Execute the instruction at the head of the queue.
	always_comb begin
		ip_n     = ip_q;
		sp_n     = sp_q;
		ax_n     = ax_q;
		cx_n     = cx_q;
		cf_n     = cf_q;
		zf_n     = zf_q;
		sf_n     = sf_q;
		of_n     = of_q;
		run_n    = run_q;
		cv_n     = 1'b0;
		cb_n     = 8'd0;
		push_n   = 1'b0;
		push_val = ax_q;
		if (run_q == RUN_OK) begin
			ip_n = ip_seq;
			case (head_data.kind)
				K_MOV_AX: ax_n = head_data.imm;
				K_MOV_CX: cx_n = head_data.imm;
				K_MOV_SP: sp_n = head_data.imm;
				K_MOV_AH: ax_n = {head_data.imm[7:0], ax_q[7:0]};
				K_MOV_AL: ax_n = {ax_q[15:8], head_data.imm[7:0]};
				K_CHAR: begin
					if (ax_q[15:8] == AH_TELETYPE) begin
						cv_n = 1'b1;
						cb_n = ax_q[7:0];
					end
				end
				K_PUSH: begin
					sp_n   = sp_q - 16'd2;
					push_n = 1'b1;
				end
				K_POP: begin
					ax_n = ram_rdata;
					sp_n = sp_q + 16'd2;
				end
				K_CALL: begin
					sp_n     = sp_q - 16'd2;
					push_n   = 1'b1;
					push_val = ip_seq;
					ip_n     = ip_seq + head_data.imm;
				end
				K_RET: begin
					ip_n = ram_rdata;
					sp_n = sp_q + 16'd2;
				end
				K_HLT: run_n = RUN_HALT;
				K_CMP: begin
					zf_n = (cmp_diff[15:0] == 16'd0);
					sf_n = cmp_diff[15];
					cf_n = cmp_diff[16];
					of_n = (ax_q[15] ^ head_data.imm[15]) & (ax_q[15] ^ cmp_diff[15]);
				end
				K_DEC: begin
					cx_n = dec_val;
					zf_n = (dec_val == 16'd0);
					sf_n = dec_val[15];
				end
				K_JCC: begin
					if (take) begin
						ip_n = ip_seq + head_data.imm;
					end
				end
				K_BAD: run_n = RUN_BAD;
				default: ;
			endcase
		end
	end

	// Stack store port: the clearing sweep owns the write port until it ends.
	always_comb begin
		if (clearing) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q[AW-1:0];
			ram_wdata = 16'd0;
		end else begin
			ram_we    = fin && push_n;
			ram_waddr = word_idx(stack_seg, sp_n);
			ram_wdata = push_val;
		end
	end

	assign ram_raddr = word_idx(stack_seg, sp_q);

	x86ex_ram #(
		.WIDTH(16),
		.DEPTH(STACK_WORDS)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Architectural state, clearing sweep and read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q        <= IP_RESET;
			sp_q        <= SP_RESET;
			ax_q        <= '0;
			cx_q        <= '0;
			cf_q        <= 1'b0;
			zf_q        <= 1'b0;
			sf_q        <= 1'b0;
			of_q        <= 1'b0;
			run_q       <= RUN_OK;
			pend_q      <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (issue) begin
				pend_q <= 1'b1;
			end else if (fin) begin
				pend_q <= 1'b0;
			end
			if (fin) begin
				ip_q  <= ip_n;
				sp_q  <= sp_n;
				ax_q  <= ax_n;
				cx_q  <= cx_n;
				cf_q  <= cf_n;
				zf_q  <= zf_n;
				sf_q  <= sf_n;
				of_q  <= of_n;
				run_q <= run_n;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fin) begin
			out_q.pad            <= '0;
			out_q.run_status     <= run_n;
			out_q.char_byte      <= cb_n;
			out_q.char_valid     <= cv_n;
			out_q.ovf_flag       <= of_n;
			out_q.sgn_flag       <= sf_n;
			out_q.zro_flag       <= zf_n;
			out_q.carry_flag     <= cf_n;
			out_q.stack_pointer  <= sp_n;
			out_q.count_register <= cx_n;
			out_q.accumulator    <= ax_n;
			out_q.fetch_address  <= {code_seg, 4'b0000} + {4'b0000, ip_n};
			out_q.next_ip        <= ip_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_data   = out_q;

endmodule

// ===== sv/x86_subset_instruction_execute.sv =====
// Channel    | Dir | Handshake                  | Contents
// s_axis     | in  | s_tvalid / s_tready        | one fetched instruction per transfer
// m_axis     | out | m_tvalid / m_tready        | machine state after each instruction
// apb        | in  | psel, penable, pwrite      | code segment (0x0), stack segment (0x4)
//
// In the execute stage POP and RET first issue a read of the stack word, which comes
// through the registered read port of the stack RAM, and complete when it returns.
// After reset the stack store is swept to zero, one word per cycle, over all
// STACK_WORDS words; s_tready stays low during the sweep.
// A four-entry queue separates decode from execute, so input keeps flowing
// while the result register waits on m_tready.
module x86_subset_instruction_execute
	import x86ex_pkg::*;
#(
	parameter int STACK_WORDS = STACK_WORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [7:0] opcode, [23:8] immediate
	input  logic [23:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] next_ip, [35:16] fetch_address, [51:36] accumulator,
	// [67:52] count_register, [83:68] stack_pointer, [84] carry_flag,
	// [85] zro_flag, [86] sgn_flag, [87] ovf_flag, [88] char_valid,
	// [96:89] char_byte, [98:97] run_status, [103:99] zero
	output logic [103:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [15:0] code_seg_q;
	logic [15:0] stack_seg_q;
	logic        reg_sel;

	logic        q_push, q_pop, q_full, q_head_valid, clearing;
	dec_t        q_in, q_head;
	res_t        res;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_seg_q  <= '0;
			stack_seg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_CODE_SEG:  code_seg_q  <= pwdata[15:0];
				default:       stack_seg_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_CODE_SEG: prdata = {16'd0, code_seg_q};
			default:      prdata = {16'd0, stack_seg_q};
		endcase
	end

	x86ex_front u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.q_full  (q_full),
		.clearing(clearing),
		.q_push  (q_push),
		.q_data  (q_in)
	);

	x86ex_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.head_valid(q_head_valid),
		.head_data (q_head)
	);

	x86ex_back #(
		.STACK_WORDS(STACK_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_seg  (code_seg_q),
		.stack_seg (stack_seg_q),
		.head_valid(q_head_valid),
		.head_data (q_head),
		.pop       (q_pop),
		.clearing  (clearing),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_data    (res)
	);

	assign m_tdata = res;

endmodule
